>>> hdl/qlcc_pkg.sv
// ----------------------------------------------------------------------------
// qlcc_pkg
// Shared types and constants for the quantized loop clip controller: item
// layouts, command and clip state codes, and fixed field widths.
// ----------------------------------------------------------------------------
package qlcc_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 8;
  localparam int POS_BITS      = 24;
  localparam int SPEED_W       = 12;
  localparam int CMD_W         = 4;
  localparam int CLIP_STATE_W  = 3;
  localparam int BEAT_W        = 10;
  localparam int FRAMES_W      = 30;
  localparam int FPB_W         = 20;
  localparam int HEAD_OUT_W    = 17;

  // store depth default for the top level
  localparam int BUF_DEPTH_DEF = 65536;

  // beat and loop length limits
  localparam logic [BEAT_W-1:0]   BEATS_PER_BAR = BEAT_W'(4);
  localparam logic [BEAT_W-1:0]   BEATS_MAX     = BEAT_W'(1023);
  localparam logic [FRAMES_W-1:0] FRAMES_MAX    = FRAMES_W'(1073741823);
  localparam logic [FPB_W-1:0]    FPB_RESET     = FPB_W'(22050);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_BAR_TICK     = 4'd0,
    CMD_QUEUE_PLAY   = 4'd1,
    CMD_QUEUE_STOP   = 4'd2,
    CMD_QUEUE_RECORD = 4'd3,
    CMD_UNQUEUE      = 4'd4,
    CMD_RECORD       = 4'd5,
    CMD_PLAY         = 4'd6,
    CMD_SEEK         = 4'd7,
    CMD_CLEAR        = 4'd8
  } cmd_e;

  // reported clip state, later entries take precedence
  typedef enum logic [CLIP_STATE_W-1:0] {
    ST_EMPTY         = 3'd0,
    ST_STOPPED       = 3'd1,
    ST_PLAYING       = 3'd2,
    ST_RECORDING     = 3'd3,
    ST_PLAY_QUEUED   = 3'd4,
    ST_STOP_QUEUED   = 3'd5,
    ST_RECORD_QUEUED = 3'd6
  } clip_state_e;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0]              command;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic [SPEED_W-1:0]            speed;
    logic [POS_BITS-1:0]           seek_position;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [CLIP_STATE_W-1:0]       clip_state;
    logic                          state_changed;
    logic                          overflow;
    logic [BEAT_W-1:0]             beat_count;
    logic [FRAMES_W-1:0]           loop_frames;
    logic [HEAD_OUT_W-1:0]         record_length;
  } out_item_t;

  // status part of a result, produced by the controller
  typedef struct packed {
    logic [CLIP_STATE_W-1:0] clip_state;
    logic                    state_changed;
    logic                    overflow;
    logic [BEAT_W-1:0]       beat_count;
    logic [FRAMES_W-1:0]     loop_frames;
    logic [HEAD_OUT_W-1:0]   record_length;
  } status_t;

  // stereo sample pair as kept in the store
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } sample_pair_t;

  // store access request
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_op_t;

endpackage

>>> hdl/qlcc_store.sv
// ----------------------------------------------------------------------------
// qlcc_store
// Stereo sample store: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module qlcc_store #(
  parameter int BUF_DEPTH = qlcc_pkg::BUF_DEPTH_DEF,
  parameter int ADDR_W    = $clog2(BUF_DEPTH)
) (
  input  logic                  clk,
  input  qlcc_pkg::mem_op_t     op,
  input  logic [ADDR_W-1:0]     addr,
  input  qlcc_pkg::sample_pair_t wdata,
  output qlcc_pkg::sample_pair_t rdata
);
  import qlcc_pkg::*;

  sample_pair_t mem [BUF_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[addr] <= wdata;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (op.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/qlcc_ctrl.sv
// ----------------------------------------------------------------------------
// qlcc_ctrl
// Clip controller state: flags, queued requests, playhead, record head, beat
// count and loop length. Updates once per accepted item and issues the store
// access for that item.
// ----------------------------------------------------------------------------
module qlcc_ctrl #(
  parameter int BUF_DEPTH = qlcc_pkg::BUF_DEPTH_DEF,
  parameter int ADDR_W    = $clog2(BUF_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  qlcc_pkg::in_item_t           item,
  input  logic                         cfg_write_en,
  input  logic [qlcc_pkg::FPB_W-1:0]   cfg_write_data,
  output qlcc_pkg::mem_op_t            mem_op,
  output logic [ADDR_W-1:0]            mem_addr,
  output qlcc_pkg::sample_pair_t       mem_wdata,
  output qlcc_pkg::status_t            status
);
  import qlcc_pkg::*;

  localparam int HEAD_W  = $clog2(BUF_DEPTH + 1);
  localparam int CMP_W   = (HEAD_W + FRAC_BITS > POS_BITS) ? HEAD_W + FRAC_BITS : POS_BITS;
  localparam int PROD_W  = FPB_W + BEAT_W;
  localparam int SUM_W   = POS_BITS + 1;
  localparam logic [CMP_W-1:0]  DEPTH_LIM = CMP_W'(BUF_DEPTH) << FRAC_BITS;
  localparam logic [HEAD_W-1:0] HEAD_MAX  = HEAD_W'(BUF_DEPTH);

  // state registers
  logic [FPB_W-1:0]    fpb;
  logic                loaded, playing, recording;
  logic                q_play, q_stop, q_record;
  logic [POS_BITS-1:0] pos;
  logic [HEAD_W-1:0]   head;
  logic [BEAT_W-1:0]   beats;
  logic [FRAMES_W-1:0] frames;

  logic                loaded_next, playing_next, recording_next;
  logic                q_play_next, q_stop_next, q_record_next;
  logic [POS_BITS-1:0] pos_next;
  logic [HEAD_W-1:0]   head_next;
  logic [BEAT_W-1:0]   beats_next;
  logic [FRAMES_W-1:0] frames_next;
  logic                changed, ovf;

  // helper values
  logic [BEAT_W:0]     beats_sum;
  logic [BEAT_W-1:0]   beats_sat, beats_bar;
  logic [PROD_W-1:0]   frames_prod;
  logic [FRAMES_W-1:0] frames_bar;
  logic [CMP_W-1:0]    pos_ext, head_lim, rd_ext;
  logic                past_len, past_store, head_full;
  logic [POS_BITS-1:0] pos_bar, pos_rd, pos_adv;
  logic [SUM_W-1:0]    pos_sum;
  logic [ADDR_W-1:0]   rd_addr;
  clip_state_e         clip_code;

  // beat growth and loop length for a bar tick while recording
  assign beats_sum   = {1'b0, beats} + {1'b0, BEATS_PER_BAR};
  assign beats_sat   = (beats_sum > {1'b0, BEATS_MAX}) ? BEATS_MAX : beats_sum[BEAT_W-1:0];
  assign beats_bar   = (loaded || playing || q_play || q_stop) ? beats_sat : beats;
  assign frames_prod = PROD_W'(fpb) * PROD_W'(beats_bar);
  assign frames_bar  = (frames_prod > PROD_W'(FRAMES_MAX)) ? FRAMES_MAX
                                                            : FRAMES_W'(frames_prod);

  // playhead restart checks
  assign pos_ext    = CMP_W'(pos);
  assign head_lim   = CMP_W'(head) << FRAC_BITS;
  assign past_len   = (pos_ext >= head_lim);
  assign past_store = (pos_ext >= DEPTH_LIM);
  assign pos_bar    = past_len ? '0 : pos;
  assign pos_rd     = (past_len || past_store) ? '0 : pos;

  // read address and playhead advance
  assign rd_ext  = CMP_W'(pos_rd);
  assign rd_addr = rd_ext[FRAC_BITS +: ADDR_W];
  assign pos_sum = {1'b0, pos_rd} + SUM_W'(item.speed);
  assign pos_adv = pos_sum[POS_BITS] ? '0 : pos_sum[POS_BITS-1:0];

  assign head_full = (head >= HEAD_MAX);

  // next state for one item
  always_comb begin
    loaded_next    = loaded;
    playing_next   = playing;
    recording_next = recording;
    q_play_next    = q_play;
    q_stop_next    = q_stop;
    q_record_next  = q_record;
    pos_next       = pos;
    head_next      = head;
    beats_next     = beats;
    frames_next    = frames;
    changed        = 1'b0;
    ovf            = 1'b0;
    mem_op         = '0;
    mem_addr       = rd_addr;
    unique case (cmd_e'(item.command))
      CMD_BAR_TICK: begin
        if (recording) begin
          beats_next  = beats_bar;
          frames_next = frames_bar;
        end
        pos_next = pos_bar;
        if (q_play && loaded) begin
          playing_next   = 1'b1;
          recording_next = 1'b0;
          q_play_next    = 1'b0;
          pos_next       = '0;
          changed        = 1'b1;
        end else if (q_stop && loaded) begin
          playing_next   = 1'b0;
          recording_next = 1'b0;
          q_stop_next    = 1'b0;
          changed        = 1'b1;
        end else if (q_record) begin
          recording_next = 1'b1;
          playing_next   = 1'b0;
          q_record_next  = 1'b0;
          beats_next     = '0;
          head_next      = '0;
          changed        = 1'b1;
        end else if (q_play) begin
          q_play_next = 1'b0;
          changed     = 1'b1;
        end
      end
      CMD_QUEUE_PLAY: begin
        q_play_next   = 1'b1;
        q_stop_next   = 1'b0;
        q_record_next = 1'b0;
      end
      CMD_QUEUE_STOP: begin
        if (loaded) begin
          q_stop_next = 1'b1;
          q_play_next = 1'b0;
        end
      end
      CMD_QUEUE_RECORD: begin
        q_record_next = 1'b1;
        q_play_next   = 1'b0;
        q_stop_next   = 1'b0;
      end
      CMD_UNQUEUE: begin
        q_play_next   = 1'b0;
        q_stop_next   = 1'b0;
        q_record_next = 1'b0;
      end
      CMD_RECORD: begin
        if (!head_full) begin
          mem_op.wr = 1'b1;
          mem_addr  = head[ADDR_W-1:0];
          head_next = head + HEAD_W'(1);
        end else begin
          ovf = 1'b1;
        end
        loaded_next = 1'b1;
      end
      CMD_PLAY: begin
        mem_op.rd = 1'b1;
        pos_next  = pos_adv;
      end
      CMD_SEEK: begin
        if (!recording && playing) begin
          pos_next = item.seek_position;
        end
      end
      CMD_CLEAR: begin
        loaded_next    = 1'b0;
        playing_next   = 1'b0;
        recording_next = 1'b0;
        q_play_next    = 1'b0;
        q_stop_next    = 1'b0;
        q_record_next  = 1'b0;
        pos_next       = '0;
        head_next      = '0;
        beats_next     = '0;
        frames_next    = '0;
      end
      default: begin
      end
    endcase
  end

  assign mem_wdata.left  = item.left_in;
  assign mem_wdata.right = item.right_in;

  // clip state code after the item
  always_comb begin
    if (q_record_next)       clip_code = ST_RECORD_QUEUED;
    else if (q_stop_next)    clip_code = ST_STOP_QUEUED;
    else if (q_play_next)    clip_code = ST_PLAY_QUEUED;
    else if (recording_next) clip_code = ST_RECORDING;
    else if (playing_next)   clip_code = ST_PLAYING;
    else if (loaded_next)    clip_code = ST_STOPPED;
    else                     clip_code = ST_EMPTY;
  end

  // status of the item
  assign status.clip_state    = clip_code;
  assign status.state_changed = changed;
  assign status.overflow      = ovf;
  assign status.beat_count    = beats_next;
  assign status.loop_frames   = frames_next;
  assign status.record_length = HEAD_OUT_W'(head_next);

  // frames per beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      fpb <= FPB_RESET;
    end else if (cfg_write_en) begin
      fpb <= cfg_write_data;
    end
  end

  // clip state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= 1'b0;
      playing   <= 1'b0;
      recording <= 1'b0;
      q_play    <= 1'b0;
      q_stop    <= 1'b0;
      q_record  <= 1'b0;
      pos       <= '0;
      head      <= '0;
      beats     <= '0;
      frames    <= '0;
    end else if (accept) begin
      loaded    <= loaded_next;
      playing   <= playing_next;
      recording <= recording_next;
      q_play    <= q_play_next;
      q_stop    <= q_stop_next;
      q_record  <= q_record_next;
      pos       <= pos_next;
      head      <= head_next;
      beats     <= beats_next;
      frames    <= frames_next;
    end
  end

  // playing and recording are exclusive
  assert property (@(posedge clk) disable iff (rst) !(playing && recording))
    else $error("clip both playing and recording");

  // record head never passes the store size
  assert property (@(posedge clk) disable iff (rst) head <= HEAD_MAX)
    else $error("record head beyond store");

  // a transition is reported only on a bar tick
  assert property (@(posedge clk) disable iff (rst)
    accept && changed |-> item.command == CMD_BAR_TICK)
    else $error("state change outside bar tick");

endmodule

>>> hdl/quantized_loop_clip_controller_unit.sv
// ----------------------------------------------------------------------------
// quantized_loop_clip_controller_unit
// Audio loop clip controller with quantized play/stop/record requests and a
// stereo sample store.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    in_item   (qlcc_pkg::in_item_t)
//   out       output     out_valid/out_ready  out_item  (qlcc_pkg::out_item_t)
//   cfg       input      cfg_write_en         cfg_write_data (frames per beat)
//
// One item per cycle sustained while the output is not stalled; an accepted
// item passes through stage one, which holds it after the state update and
// store access, and then the result register. Reset clears the clip state and
// pipeline but not the store. A stalled output holds its item and the item
// behind it; the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module quantized_loop_clip_controller_unit #(
  parameter int BUF_DEPTH = qlcc_pkg::BUF_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qlcc_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qlcc_pkg::out_item_t        out_item,
  input  logic                       cfg_write_en,
  input  logic [qlcc_pkg::FPB_W-1:0] cfg_write_data
);
  import qlcc_pkg::*;

  localparam int ADDR_W = $clog2(BUF_DEPTH);

  logic              accept, advance;
  mem_op_t           mem_op;
  logic [ADDR_W-1:0] mem_addr;
  sample_pair_t      mem_wdata, mem_rdata;
  status_t           status;

  // stage one: status waiting for store read data
  logic              s1_valid;
  logic              s1_play;
  status_t           s1_status;

  // flow control
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  // clip controller
  qlcc_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (in_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mem_op         (mem_op),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .status         (status)
  );

  // sample store, accessed only for accepted items
  mem_op_t store_op;
  assign store_op.wr = accept && mem_op.wr;
  assign store_op.rd = accept && mem_op.rd;

  qlcc_store #(
    .BUF_DEPTH (BUF_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .op    (store_op),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status;
      s1_play   <= mem_op.rd;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // result register payload, samples only for play
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_item.left_out      <= s1_play ? mem_rdata.left  : '0;
      out_item.right_out     <= s1_play ? mem_rdata.right : '0;
      out_item.clip_state    <= s1_status.clip_state;
      out_item.state_changed <= s1_status.state_changed;
      out_item.overflow      <= s1_status.overflow;
      out_item.beat_count    <= s1_status.beat_count;
      out_item.loop_frames   <= s1_status.loop_frames;
      out_item.record_length <= s1_status.record_length;
    end
  end

  // an accepted item always lands in stage one
  assert property (@(posedge clk) disable iff (rst) accept |=> s1_valid)
    else $error("accepted item lost before stage one");

  // a blocked stage one keeps its item
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_status))
    else $error("stage one item dropped while output stalled");

  // no item is taken while both stages are full and the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !accept)
    else $error("item accepted into a full pipeline");

endmodule

>>> tb/sv/quantized_loop_clip_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_loop_clip_controller_unit_test
// Self-checking bench for the loop clip controller. A short table of
// directed commands comes first, partly with hand-written results. Three
// random phases follow, each at its own frames-per-beat setting and idle
// pattern. A long take that saturates the beat count and loop length closes
// the run. Every result is checked field by field against its hand-written
// result or a behavioral clip model kept in step with the accepted commands.
// ----------------------------------------------------------------------------
module quantized_loop_clip_controller_unit_test;
  import qlcc_pkg::*;

  localparam int STORE_DEPTH = BUF_DEPTH_DEF;
  localparam int FIRST_UNUSED_CMD = int'(CMD_CLEAR) + 1;
  localparam int LAST_CMD_CODE = 2**CMD_W - 1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;
  localparam logic [FPB_W-1:0] FPB_MAX = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // dut ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_write_en = 1'b0;
  logic [FPB_W-1:0] cfg_write_data = '0;

  // idle pattern, percent of cycles
  int unsigned send_idle_pct = 9;
  int unsigned recv_stall_pct = 56;

  out_item_t pending_results[$];
  int unsigned mismatch_count = 0;

  // clip model state
  logic [FPB_W-1:0] m_fpb = FPB_RESET;
  bit m_loaded = 1'b0, m_playing = 1'b0, m_recording = 1'b0;
  bit m_q_play = 1'b0, m_q_stop = 1'b0, m_q_record = 1'b0;
  logic [POS_BITS-1:0] m_playhead = '0;
  logic [HEAD_OUT_W-1:0] m_head = '0;
  logic [BEAT_W-1:0] m_beats = '0;
  logic [FRAMES_W-1:0] m_frames = '0;
  logic [SAMPLE_BITS-1:0] m_left [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] m_right [STORE_DEPTH];
  bit m_written [STORE_DEPTH];

  quantized_loop_clip_controller_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic clip_state_e clip_code();
    clip_state_e s;
    s = ST_EMPTY;
    if (m_loaded) s = ST_STOPPED;
    if (m_playing) s = ST_PLAYING;
    if (m_recording) s = ST_RECORDING;
    if (m_q_play) s = ST_PLAY_QUEUED;
    if (m_q_stop) s = ST_STOP_QUEUED;
    if (m_q_record) s = ST_RECORD_QUEUED;
    return s;
  endfunction

  // playhead at or past the recorded length; the store-size bound can
  // never trip since a 24 bit playhead stays below depth << 8
  function automatic bit playhead_past_end();
    return {1'b0, m_playhead} >= {m_head, FRAC_BITS'(0)};
  endfunction

  // store entry the next play sample will read
  function automatic logic [15:0] next_play_index();
    return playhead_past_end() ? 16'd0 : m_playhead[POS_BITS-1:FRAC_BITS];
  endfunction

  function automatic out_item_t clip_model_step(in_item_t it);
    out_item_t res;
    logic [POS_BITS:0] sum;
    logic [BEAT_W:0] bsum;
    logic [FPB_W+BEAT_W-1:0] prod;
    logic [15:0] idx;
    res = '0;
    case (it.command)
      CMD_BAR_TICK: begin
        // beat count and loop length follow the take
        if (m_recording) begin
          if (m_loaded || m_playing || m_q_play || m_q_stop) begin
            bsum = {1'b0, m_beats} + BEATS_PER_BAR;
            m_beats = (bsum > BEATS_MAX) ? BEATS_MAX : bsum[BEAT_W-1:0];
          end
          prod = m_fpb * m_beats;
          m_frames = (prod > FRAMES_MAX) ? FRAMES_MAX : prod[FRAMES_W-1:0];
        end
        if (playhead_past_end()) m_playhead = '0;
        // at most one queued request applies, in priority order
        if (m_q_play && m_loaded) begin
          m_playing = 1'b1;
          m_recording = 1'b0;
          m_q_play = 1'b0;
          m_playhead = '0;
          res.state_changed = 1'b1;
        end else if (m_q_stop && m_loaded) begin
          m_playing = 1'b0;
          m_recording = 1'b0;
          m_q_stop = 1'b0;
          res.state_changed = 1'b1;
        end else if (m_q_record) begin
          m_recording = 1'b1;
          m_playing = 1'b0;
          m_q_record = 1'b0;
          m_beats = '0;
          m_head = '0;
          res.state_changed = 1'b1;
        end else if (m_q_play) begin
          m_q_play = 1'b0;
          res.state_changed = 1'b1;
        end
      end
      CMD_QUEUE_PLAY: begin
        m_q_play = 1'b1;
        m_q_stop = 1'b0;
        m_q_record = 1'b0;
      end
      CMD_QUEUE_STOP: begin
        if (m_loaded) begin
          m_q_stop = 1'b1;
          m_q_play = 1'b0;
        end
      end
      CMD_QUEUE_RECORD: begin
        m_q_record = 1'b1;
        m_q_play = 1'b0;
        m_q_stop = 1'b0;
      end
      CMD_UNQUEUE: begin
        m_q_play = 1'b0;
        m_q_stop = 1'b0;
        m_q_record = 1'b0;
      end
      CMD_RECORD: begin
        if (m_head < HEAD_OUT_W'(STORE_DEPTH)) begin
          m_left[m_head[15:0]] = it.left_in;
          m_right[m_head[15:0]] = it.right_in;
          m_written[m_head[15:0]] = 1'b1;
          m_head = m_head + 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
        m_loaded = 1'b1;
      end
      CMD_PLAY: begin
        if (playhead_past_end()) m_playhead = '0;
        idx = m_playhead[POS_BITS-1:FRAC_BITS];
        res.left_out = m_left[idx];
        res.right_out = m_right[idx];
        sum = {1'b0, m_playhead} + it.speed;
        m_playhead = sum[POS_BITS] ? '0 : sum[POS_BITS-1:0];
      end
      CMD_SEEK: begin
        if (!m_recording && m_playing) m_playhead = it.seek_position;
      end
      CMD_CLEAR: begin
        m_loaded = 1'b0;
        m_playing = 1'b0;
        m_recording = 1'b0;
        m_q_play = 1'b0;
        m_q_stop = 1'b0;
        m_q_record = 1'b0;
        m_playhead = '0;
        m_head = '0;
        m_beats = '0;
        m_frames = '0;
      end
      default: begin
      end
    endcase
    res.clip_state = clip_code();
    res.beat_count = m_beats;
    res.loop_frames = m_frames;
    res.record_length = m_head;
    return res;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic in_item_t in_of(logic [CMD_W-1:0] c, logic [SAMPLE_BITS-1:0] l,
                                     logic [SAMPLE_BITS-1:0] r, logic [SPEED_W-1:0] s,
                                     logic [POS_BITS-1:0] p);
    in_item_t it;
    it.command = c;
    it.left_in = l;
    it.right_in = r;
    it.speed = s;
    it.seek_position = p;
    return it;
  endfunction

  function automatic out_item_t res_of(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                                       clip_state_e st, bit chg, bit ovf,
                                       logic [BEAT_W-1:0] bt, logic [FRAMES_W-1:0] fr,
                                       logic [HEAD_OUT_W-1:0] rl);
    out_item_t res;
    res.left_out = l;
    res.right_out = r;
    res.clip_state = st;
    res.state_changed = chg;
    res.overflow = ovf;
    res.beat_count = bt;
    res.loop_frames = fr;
    res.record_length = rl;
    return res;
  endfunction

  // random command, weighted by what the clip is doing
  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned r;
    it.left_in = SAMPLE_BITS'($urandom());
    it.right_in = SAMPLE_BITS'($urandom());
    it.speed = ($urandom_range(0, 4) != 0) ? SPEED_W'($urandom_range(0, 'h200))
                                           : SPEED_W'($urandom());
    it.seek_position = ($urandom_range(0, 3) == 0) ? POS_BITS'($urandom())
        : POS_BITS'($urandom_range(0, int'({m_head, 8'hFF})));
    r = $urandom_range(0, 99);
    if (m_recording) begin
      if (r < 55) it.command = CMD_RECORD;
      else if (r < 70) it.command = CMD_BAR_TICK;
      else if (r < 78) it.command = CMD_QUEUE_PLAY;
      else if (r < 84) it.command = CMD_QUEUE_STOP;
      else if (r < 87) it.command = CMD_QUEUE_RECORD;
      else if (r < 90) it.command = CMD_PLAY;
      else if (r < 93) it.command = CMD_SEEK;
      else if (r < 96) it.command = CMD_UNQUEUE;
      else if (r < 97) it.command = CMD_CLEAR;
      else it.command = CMD_W'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD_CODE));
    end else if (m_playing) begin
      if (r < 52) it.command = CMD_PLAY;
      else if (r < 64) it.command = CMD_SEEK;
      else if (r < 77) it.command = CMD_BAR_TICK;
      else if (r < 82) it.command = CMD_QUEUE_STOP;
      else if (r < 86) it.command = CMD_QUEUE_RECORD;
      else if (r < 90) it.command = CMD_QUEUE_PLAY;
      else if (r < 94) it.command = CMD_RECORD;
      else if (r < 96) it.command = CMD_UNQUEUE;
      else if (r < 97) it.command = CMD_CLEAR;
      else it.command = CMD_W'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD_CODE));
    end else begin
      if (r < 25) it.command = CMD_QUEUE_RECORD;
      else if (r < 45) it.command = CMD_BAR_TICK;
      else if (r < 60) it.command = CMD_QUEUE_PLAY;
      else if (r < 68) it.command = CMD_RECORD;
      else if (r < 75) it.command = CMD_QUEUE_STOP;
      else if (r < 80) it.command = CMD_PLAY;
      else if (r < 85) it.command = CMD_SEEK;
      else if (r < 90) it.command = CMD_UNQUEUE;
      else if (r < 94) it.command = CMD_CLEAR;
      else it.command = CMD_W'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD_CODE));
    end
    // never read a store entry that holds nothing since reset
    if (it.command == CMD_PLAY && !m_written[next_play_index()]) it.command = CMD_RECORD;
    return it;
  endfunction

  // predict, queue the expectation, then hand the item over
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t typed_res = '0);
    out_item_t exp_res;
    exp_res = clip_model_step(it);
    if (typed) exp_res = typed_res;
    pending_results.push_back(exp_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_frames_per_beat(logic [FPB_W-1:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    m_fpb = v;
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // now and then hold off until the block has drained
      if ($urandom_range(0, 99) == 0) wait_for_results();
      send_item(random_item());
    end
  endtask

  // ------------------------------------------------------------- checking

  task automatic flag_field(string name, longint unsigned want, longint unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, out_item);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.left_out !== want.left_out)
          flag_field("left_out", want.left_out, out_item.left_out);
        if (out_item.right_out !== want.right_out)
          flag_field("right_out", want.right_out, out_item.right_out);
        if (out_item.clip_state !== want.clip_state)
          flag_field("clip_state", want.clip_state, out_item.clip_state);
        if (out_item.state_changed !== want.state_changed)
          flag_field("state_changed", want.state_changed, out_item.state_changed);
        if (out_item.overflow !== want.overflow)
          flag_field("overflow", want.overflow, out_item.overflow);
        if (out_item.beat_count !== want.beat_count)
          flag_field("beat_count", want.beat_count, out_item.beat_count);
        if (out_item.loop_frames !== want.loop_frames)
          flag_field("loop_frames", want.loop_frames, out_item.loop_frames);
        if (out_item.record_length !== want.record_length)
          flag_field("record_length", want.record_length, out_item.record_length);
      end
    end
  end

  // ----------------------------------------------------------------- main

  typedef struct {
    in_item_t item;
    bit typed;
    out_item_t res;
  } cmd_row_t;

  cmd_row_t cmd_table[$];

  initial begin
    // directed commands at the reset frames per beat
    cmd_table.push_back('{in_of(CMD_UNQUEUE, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_EMPTY, 0, 0, 0, 0, 0)});
    // stop request on an empty clip is ignored
    cmd_table.push_back('{in_of(CMD_QUEUE_STOP, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_EMPTY, 0, 0, 0, 0, 0)});
    cmd_table.push_back('{in_of(CMD_QUEUE_PLAY, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_PLAY_QUEUED, 0, 0, 0, 0, 0)});
    // play request on an empty clip is dropped at the bar
    cmd_table.push_back('{in_of(CMD_BAR_TICK, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_EMPTY, 1, 0, 0, 0, 0)});
    cmd_table.push_back('{in_of(CMD_QUEUE_RECORD, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_RECORD_QUEUED, 0, 0, 0, 0, 0)});
    cmd_table.push_back('{in_of(CMD_BAR_TICK, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_RECORDING, 1, 0, 0, 0, 0)});
    cmd_table.push_back('{in_of(CMD_RECORD, SAMPLE_MAX, SAMPLE_MIN, 0, 0), 1'b1,
                          res_of(0, 0, ST_RECORDING, 0, 0, 0, 0, 1)});
    cmd_table.push_back('{in_of(CMD_RECORD, SAMPLE_MIN, SAMPLE_MAX, 0, 0), 1'b1,
                          res_of(0, 0, ST_RECORDING, 0, 0, 0, 0, 2)});
    cmd_table.push_back('{in_of(CMD_RECORD, 0, '1, 0, 0), 1'b1,
                          res_of(0, 0, ST_RECORDING, 0, 0, 0, 0, 3)});
    // loaded take grows by a bar
    cmd_table.push_back('{in_of(CMD_BAR_TICK, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_RECORDING, 0, 0, 4, 88200, 3)});
    // seek while recording is ignored
    cmd_table.push_back('{in_of(CMD_SEEK, 0, 0, 0, 'h100), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_QUEUE_PLAY, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_PLAY_QUEUED, 0, 0, 4, 88200, 3)});
    cmd_table.push_back('{in_of(CMD_BAR_TICK, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_PLAYING, 1, 0, 8, 176400, 3)});
    cmd_table.push_back('{in_of(CMD_PLAY, 0, 0, 'h100, 0), 1'b1,
                          res_of(SAMPLE_MAX, SAMPLE_MIN, ST_PLAYING, 0, 0, 8, 176400, 3)});
    cmd_table.push_back('{in_of(CMD_PLAY, 0, 0, SPEED_MAX, 0), 1'b0, '0});
    // playhead past the take restarts at zero
    cmd_table.push_back('{in_of(CMD_PLAY, 0, 0, 0, 0), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_SEEK, 0, 0, 0, 'h280), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_PLAY, 0, 0, 'h80, 0), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_SEEK, 0, 0, 0, POS_MAX), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_PLAY, 0, 0, 0, 0), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_W'(LAST_CMD_CODE), SAMPLE_MAX, SAMPLE_MAX, SPEED_MAX,
                                POS_MAX), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_QUEUE_STOP, 0, 0, 0, 0), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_BAR_TICK, 0, 0, 0, 0), 1'b0, '0});
    // record while stopped still writes
    cmd_table.push_back('{in_of(CMD_RECORD, 'h123456, 'h654321, 0, 0), 1'b0, '0});
    cmd_table.push_back('{in_of(CMD_CLEAR, 0, 0, 0, 0), 1'b1,
                          res_of(0, 0, ST_EMPTY, 0, 0, 0, 0, 0)});
    // play after clear reads the kept first entry
    cmd_table.push_back('{in_of(CMD_PLAY, 0, 0, 'h40, 0), 1'b0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (cmd_table[i]) send_item(cmd_table[i].item, cmd_table[i].typed, cmd_table[i].res);
    wait_for_results();

    // random phase, smallest beat length
    write_frames_per_beat(FPB_W'(1));
    run_random(120);
    wait_for_results();

    // random phase, largest beat length, idle pattern swapped
    send_idle_pct = 56;
    recv_stall_pct = 9;
    write_frames_per_beat(FPB_MAX);
    run_random(120);
    wait_for_results();

    // random phase, random beat length, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_frames_per_beat(FPB_W'($urandom_range(1, 2**FPB_W - 1)));
    run_random(120);
    wait_for_results();

    // long take: saturate the beat count and the loop length
    write_frames_per_beat(FPB_MAX);
    send_item(in_of(CMD_CLEAR, 0, 0, 0, 0));
    send_item(in_of(CMD_QUEUE_RECORD, 0, 0, 0, 0));
    send_item(in_of(CMD_BAR_TICK, 0, 0, 0, 0));
    for (int i = 0; i < 264; i++) begin
      if (i % 16 == 0)
        send_item(in_of(CMD_RECORD, SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
                        SPEED_W'($urandom()), POS_BITS'($urandom())));
      send_item(in_of(CMD_BAR_TICK, 0, 0, 0, 0));
    end
    send_item(in_of(CMD_QUEUE_PLAY, 0, 0, 0, 0));
    send_item(in_of(CMD_BAR_TICK, 0, 0, 0, 0));
    // seek past the take, then fast steps across entries
    send_item(in_of(CMD_SEEK, 0, 0, 0, 'hFFFF00));
    send_item(in_of(CMD_PLAY, 0, 0, SPEED_MAX, 0));
    send_item(in_of(CMD_PLAY, 0, 0, SPEED_MAX, 0));
    send_item(in_of(CMD_SEEK, 0, 0, 0, POS_MAX));
    send_item(in_of(CMD_PLAY, 0, 0, 12'h001, 0));
    send_item(in_of(CMD_PLAY, 0, 0, 12'h001, 0));
    // record while playing and while stopped
    send_item(in_of(CMD_RECORD, SAMPLE_MAX, SAMPLE_MIN, 0, 0));
    send_item(in_of(CMD_QUEUE_STOP, 0, 0, 0, 0));
    send_item(in_of(CMD_BAR_TICK, 0, 0, 0, 0));
    send_item(in_of(CMD_RECORD, SAMPLE_MIN, SAMPLE_MAX, 0, 0));
    run_random(40);
    wait_for_results();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
